>>> sv/kpe_pkg.sv
// Package for the k-permutation enumerator: sizes, array types and state codes.
// Used by every module of the block; depends on nothing.
package kpe_pkg;

  localparam int MaxLetters = 8;
  localparam int IdxW       = $clog2(MaxLetters);
  localparam int CntW       = $clog2(MaxLetters + 1);
  localparam int LetterW    = 8;
  localparam int WordW      = MaxLetters * LetterW;
  localparam int LenW       = 4;
  localparam int AddrW      = 4;
  localparam int DataW      = 64;
  localparam int RegSelBit  = 3;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef idx_t [MaxLetters-1:0] idx_arr_t;
  typedef logic [MaxLetters-1:0][LetterW-1:0] word_arr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ORD_LOAD,
    ST_ORD_PIVOT,
    ST_ORD_SUCC,
    ST_REV_READ,
    ST_REV_SWAP,
    ST_SET_INIT,
    ST_SET_SCAN,
    ST_EMIT,
    ST_OUT
  } kpe_state_e;

  function automatic cnt_t eff_count(input logic [LenW-1:0] cnt);
    if (cnt > LenW'(MaxLetters)) begin
      return CntW'(MaxLetters);
    end
    return CntW'(cnt);
  endfunction

endpackage

>>> sv/kpe_regs.sv
// Configuration registers of the k-permutation enumerator behind an APB-style port.
// Depends on kpe_pkg.
module kpe_regs
  import kpe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output word_arr_t        letters_o,
  output cnt_t             count_o
);

  logic [WordW-1:0] letters_q;
  logic [LenW-1:0]  count_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letters_q <= '0;
      count_q   <= LenW'(1);
    end else if (wr_en) begin
      if (paddr[RegSelBit]) begin
        count_q <= pwdata[LenW-1:0];
      end else begin
        letters_q <= pwdata[WordW-1:0];
      end
    end
  end

  assign prdata    = paddr[RegSelBit] ? {{(DataW-LenW){1'b0}}, count_q} : DataW'(letters_q);
  assign letters_o = word_arr_t'(letters_q);
  assign count_o   = eff_count(count_q);

endmodule

>>> sv/k_permutation_enumerator.sv
// Top level of the k-permutation enumerator: request channel, word channel, sequencer.
// Depends on kpe_pkg and kpe_regs.
//
// Each request word on the input channel (restart_i) asks for the next arrangement of the
// configured letters; restart_i high starts over at the first word. Every request gives
// exactly one word on the output channel: word_o holds the letters, byte 0 first, and
// word_length_o their number. When every arrangement has been given, done_res_o is high
// and word_o and word_length_o are zero. Sizes run from 1 to the letter count; within a
// size the position sets and then their orderings follow in lexicographic order.
// One request is worked at a time by a sequencer that reads one position of the ordering
// and one of the chosen set per cycle. When the run is already over or the count is zero,
// the answer goes straight to the output state; otherwise the pivot and successor scans,
// the suffix reversal and the per-letter assembly each step through the positions in turn.
// in_stall_o is high from acceptance until the result is loaded into the output register.
// A stalled output holds its word; the next request may be accepted meanwhile.
// Reset clears the registers to letters zero and count one and forgets any run.
module k_permutation_enumerator
  import kpe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             restart_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WordW-1:0] word_o,
  output logic [LenW-1:0]  word_length_o,
  output logic             done_res_o
);

  word_arr_t  letters;
  cnt_t       n;

  kpe_state_e state_q, state_d;
  cnt_t       size_q, size_d;
  idx_arr_t   ord_q, ord_d;
  idx_arr_t   chs_q, chs_d;
  logic       started_q, started_d;
  logic       exh_q, exh_d;
  logic       done_q, done_d;
  idx_t       idx_q, idx_d;
  idx_t       hi_q, hi_d;
  idx_t       pivot_q, pivot_d;
  idx_t       last_q, last_d;
  idx_t       pval_q, pval_d;
  word_arr_t  w_q, w_d;

  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_word_q, out_word_d;
  logic [LenW-1:0]  out_len_q, out_len_d;
  logic             out_done_q, out_done_d;

  idx_t ord_ra, chs_ra, ord_rd, chs_rd, size_m1, base;
  cnt_t limit;
  logic set_fail;

  kpe_regs u_kpe_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .letters_o (letters),
    .count_o   (n)
  );

  function automatic idx_arr_t first_set(input cnt_t size);
    idx_arr_t f;
    for (int i = 0; i < MaxLetters; i++) begin
      f[i] = (CntW'(i) < size) ? IdxW'(i) : '0;
    end
    return f;
  endfunction

  assign size_m1 = IdxW'(size_q - CntW'(1));
  assign ord_ra  = (state_q == ST_REV_SWAP) ? hi_q : idx_q;
  assign ord_rd  = ord_q[ord_ra];
  assign chs_ra  = (state_q == ST_EMIT) ? ord_rd : idx_q;
  assign chs_rd  = chs_q[chs_ra];
  assign limit   = n - size_q + CntW'(idx_q);
  assign base    = chs_rd + IdxW'(1);

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    ord_d       = ord_q;
    chs_d       = chs_q;
    started_d   = started_q;
    exh_d       = exh_q;
    done_d      = done_q;
    idx_d       = idx_q;
    hi_d        = hi_q;
    pivot_d     = pivot_q;
    last_d      = last_q;
    pval_d      = pval_q;
    w_d         = w_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_word_d  = out_word_q;
    out_len_d   = out_len_q;
    out_done_d  = out_done_q;
    set_fail    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (restart_i || !started_q) begin
            started_d = 1'b1;
            exh_d     = 1'b0;
            if (n == '0) begin
              size_d  = '0;
              ord_d   = first_set('0);
              chs_d   = first_set('0);
              exh_d   = 1'b1;
              done_d  = 1'b1;
              state_d = ST_OUT;
            end else begin
              size_d  = CntW'(1);
              ord_d   = first_set(CntW'(1));
              chs_d   = first_set(CntW'(1));
              idx_d   = '0;
              w_d     = '0;
              done_d  = 1'b0;
              state_d = ST_EMIT;
            end
          end else if (exh_q) begin
            done_d  = 1'b1;
            state_d = ST_OUT;
          end else begin
            done_d = 1'b0;
            idx_d  = size_m1;
            if (size_q < CntW'(2)) begin
              state_d = ST_SET_INIT;
            end else begin
              state_d = ST_ORD_LOAD;
            end
          end
        end
      end
      ST_ORD_LOAD: begin
        last_d  = ord_rd;
        idx_d   = idx_q - IdxW'(1);
        state_d = ST_ORD_PIVOT;
      end
      ST_ORD_PIVOT: begin
        if (ord_rd < last_q) begin
          pivot_d = idx_q;
          pval_d  = ord_rd;
          idx_d   = size_m1;
          state_d = ST_ORD_SUCC;
        end else begin
          last_d = ord_rd;
          if (idx_q == '0) begin
            state_d = ST_SET_INIT;
          end else begin
            idx_d = idx_q - IdxW'(1);
          end
        end
      end
      ST_ORD_SUCC: begin
        if (ord_rd > pval_q) begin
          ord_d[pivot_q] = ord_rd;
          ord_d[idx_q]   = pval_q;
          idx_d          = pivot_q + IdxW'(1);
          hi_d           = size_m1;
          state_d        = ST_REV_READ;
        end else begin
          idx_d = idx_q - IdxW'(1);
        end
      end
      ST_REV_READ: begin
        if (idx_q < hi_q) begin
          last_d  = ord_rd;
          state_d = ST_REV_SWAP;
        end else begin
          idx_d   = '0;
          w_d     = '0;
          state_d = ST_EMIT;
        end
      end
      ST_REV_SWAP: begin
        ord_d[idx_q] = ord_rd;
        ord_d[hi_q]  = last_q;
        idx_d        = idx_q + IdxW'(1);
        hi_d         = hi_q - IdxW'(1);
        state_d      = ST_REV_READ;
      end
      ST_SET_INIT: begin
        if (size_q > n) begin
          set_fail = 1'b1;
        end else begin
          idx_d   = size_m1;
          state_d = ST_SET_SCAN;
        end
      end
      ST_SET_SCAN: begin
        if (CntW'(chs_rd) < limit) begin
          for (int k = 0; k < MaxLetters; k++) begin
            if (IdxW'(k) > idx_q && CntW'(k) < size_q) begin
              chs_d[k] = base + IdxW'(k) - idx_q;
            end
            if (CntW'(k) < size_q) begin
              ord_d[k] = IdxW'(k);
            end
          end
          chs_d[idx_q] = base;
          idx_d        = '0;
          w_d          = '0;
          state_d      = ST_EMIT;
        end else if (idx_q == '0) begin
          set_fail = 1'b1;
        end else begin
          idx_d = idx_q - IdxW'(1);
        end
      end
      ST_EMIT: begin
        w_d[idx_q] = letters[chs_rd];
        if (CntW'(idx_q) == size_q - CntW'(1)) begin
          state_d = ST_OUT;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_word_d  = done_q ? '0 : WordW'(w_q);
          out_len_d   = done_q ? '0 : LenW'(size_q);
          out_done_d  = done_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (set_fail) begin
      if (size_q >= n || size_q >= CntW'(MaxLetters)) begin
        exh_d   = 1'b1;
        done_d  = 1'b1;
        state_d = ST_OUT;
      end else begin
        size_d  = size_q + CntW'(1);
        ord_d   = first_set(size_q + CntW'(1));
        chs_d   = first_set(size_q + CntW'(1));
        idx_d   = '0;
        w_d     = '0;
        state_d = ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= '0;
      started_q   <= 1'b0;
      exh_q       <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      started_q   <= started_d;
      exh_q       <= exh_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ord_q      <= ord_d;
    chs_q      <= chs_d;
    idx_q      <= idx_d;
    hi_q       <= hi_d;
    pivot_q    <= pivot_d;
    last_q     <= last_d;
    pval_q     <= pval_d;
    w_q        <= w_d;
    out_word_q <= out_word_d;
    out_len_q  <= out_len_d;
    out_done_q <= out_done_d;
  end

  assign out_valid_o   = out_valid_q;
  assign word_o        = out_word_q;
  assign word_length_o = out_len_q;
  assign done_res_o    = out_done_q;

endmodule

>>> sv/kpe_checker.sv
// Port-level checks for the k-permutation enumerator, bound to the top level.
// Depends on kpe_pkg and k_permutation_enumerator.
module kpe_checker
  import kpe_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [WordW-1:0] word_o,
  input logic [LenW-1:0]  word_length_o,
  input logic             done_res_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Request channel not stalled after a request was taken.");

  a_done_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> word_o == '0 && word_length_o == '0)
    else $error("Done answer carries a nonempty word.");

  a_length_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |->
      word_length_o != '0 && word_length_o <= LenW'(MaxLetters))
    else $error("Word length out of range.");

  a_top_byte_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && word_length_o < LenW'(MaxLetters) |->
      word_o[WordW-1:WordW-LetterW] == '0)
    else $error("Unused top byte of a short word is not zero.");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(word_o))
    else $error("Stalled word changed or was dropped.");

endmodule

bind k_permutation_enumerator kpe_checker u_kpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .word_o        (word_o),
  .word_length_o (word_length_o),
  .done_res_o    (done_res_o)
);

>>> dv/k_permutation_enumerator_test.sv
// Self-checking testbench for k_permutation_enumerator: directed and random restart requests,
// APB register setup between phases, and a predictor of the word sequence.
// Depends on kpe_pkg and the k_permutation_enumerator RTL.
module k_permutation_enumerator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kpe_pkg::*;

  localparam int RandomItems = 1600;
  localparam int CycleLimit  = 1_000_000;
  localparam int HoldCycles  = 300;
  localparam int ReportMax   = 10;

  localparam logic [AddrW-1:0] LettersAddr = '0;
  localparam logic [AddrW-1:0] CountAddr   = AddrW'(1 << RegSelBit);

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [LenW-1:0]  length;
    logic             done;
  } answer_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             restart_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [WordW-1:0] word_o;
  logic [LenW-1:0]  word_length_o;
  logic             done_res_o;

  k_permutation_enumerator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_o       (word_o),
    .word_length_o(word_length_o),
    .done_res_o   (done_res_o)
  );

  logic    requests_q[$];
  answer_t pending_words[$];

  int unsigned queued_n;
  int unsigned accepted_n;
  int unsigned restarts_n;
  int unsigned words_n;
  int unsigned done_n;
  int unsigned settings_n;
  int unsigned fails;
  int unsigned cycle_n;
  int unsigned send_gap;
  int unsigned stall_gap;
  int unsigned idle_pct = 15;
  int unsigned hold_left;
  logic        hold_done;
  logic        calm = 1'b0;

  // Shadow of the registers and of the enumeration state.
  logic [DataW-1:0] letters_reg = '0;
  logic [LenW-1:0]  count_reg = LenW'(1);
  int unsigned      sz;
  int unsigned      pos_set[MaxLetters];
  int unsigned      perm[MaxLetters];
  logic             run_started = 1'b0;
  logic             run_over = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void first_of_size();
    for (int i = 0; i < MaxLetters; i++) begin
      pos_set[i] = (i < sz) ? i : 0;
      perm[i]    = (i < sz) ? i : 0;
    end
  endfunction

  function automatic logic step_ordering();
    int i;
    int j;
    int lo;
    int hi;
    int unsigned t;
    if (sz < 2) return 1'b0;
    i = sz - 1;
    while (i > 0 && perm[i-1] >= perm[i]) i--;
    if (i == 0) return 1'b0;
    i--;
    j = sz - 1;
    while (perm[j] <= perm[i]) j--;
    t = perm[i];
    perm[i] = perm[j];
    perm[j] = t;
    lo = i + 1;
    hi = sz - 1;
    while (lo < hi) begin
      t = perm[lo];
      perm[lo] = perm[hi];
      perm[hi] = t;
      lo++;
      hi--;
    end
    return 1'b1;
  endfunction

  function automatic logic step_position_set(input int unsigned n);
    if (sz == 0 || sz > n) return 1'b0;
    for (int i = sz - 1; i >= 0; i--) begin
      if (pos_set[i] < n - sz + i) begin
        pos_set[i]++;
        for (int k = i + 1; k < sz; k++) pos_set[k] = pos_set[k-1] + 1;
        for (int k = 0; k < sz; k++) perm[k] = k;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic answer_t spell_word();
    answer_t a;
    a = '0;
    for (int k = 0; k < sz; k++) begin
      a.word[LetterW*k +: LetterW] = letters_reg[LetterW*pos_set[perm[k]] +: LetterW];
    end
    a.length = LenW'(sz);
    return a;
  endfunction

  function automatic answer_t advance_enumeration(input logic restart);
    answer_t     finished;
    int unsigned n;
    finished = '0;
    finished.done = 1'b1;
    n = (int'(count_reg) > MaxLetters) ? MaxLetters : int'(count_reg);
    if (restart || !run_started) begin
      run_started = 1'b1;
      run_over = 1'b0;
      if (n == 0) begin
        sz = 0;
        first_of_size();
        run_over = 1'b1;
        return finished;
      end
      sz = 1;
      first_of_size();
      return spell_word();
    end
    if (run_over) return finished;
    if (!step_ordering() && !step_position_set(n)) begin
      if (sz >= n || sz >= MaxLetters) begin
        run_over = 1'b1;
        return finished;
      end
      sz++;
      first_of_size();
    end
    return spell_word();
  endfunction

  function automatic void report_failure(input string what, input answer_t exp,
                                         input answer_t got);
    fails++;
    if (fails <= ReportMax) begin
      $display("%s: expected word %h length %0d done %b, got word %h length %0d done %b",
               what, exp.word, exp.length, exp.done, got.word, got.length, got.done);
    end
  endfunction

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        pending_words.push_back(advance_enumeration(restart_i));
        accepted_n++;
        if (restart_i) restarts_n++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(0, 18);
          in_valid_i <= 1'b0;
        end else if (requests_q.size() != 0) begin
          in_valid_i <= 1'b1;
          restart_i  <= requests_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // One long hold-off on the word channel so that the block backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_n >= 100 && requests_q.size() >= 8) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Word monitor and checker.
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got;
    answer_t exp;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_gap = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got.word   = word_o;
        got.length = word_length_o;
        got.done   = done_res_o;
        if (got.done) done_n++;
        else words_n++;
        if (pending_words.size() == 0) begin
          report_failure("word with no request outstanding", '0, got);
        end else begin
          exp = pending_words.pop_front();
          if (got.word !== exp.word || got.length !== exp.length || got.done !== exp.done) begin
            report_failure("mismatch", exp, got);
          end
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
      end else if (stall_gap != 0) begin
        stall_gap--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        stall_gap = $urandom_range(0, 18);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_n++;
    if (cycle_n >= CycleLimit) begin
      $display("Watchdog expired after %0d cycles with %0d answers outstanding",
               cycle_n, pending_words.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic reg_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == LettersAddr) letters_reg = data;
    else if (addr == CountAddr) count_reg = data[LenW-1:0];
    settings_n++;
  endtask

  task automatic queue_request(input logic restart);
    requests_q.push_back(restart);
    queued_n++;
  endtask

  task automatic drain();
    while (accepted_n != queued_n || pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [DataW-1:0] lv;
    logic [DataW-1:0] pw;
    int unsigned      cnt;
    int unsigned      n_eff;
    int unsigned      total;
    int unsigned      prod;
    int unsigned      mode;
    int unsigned      run_len;
    int unsigned      random_n;
    random_n = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: a request without restart before any start acts as one.
    queue_request(1'b0);
    queue_request(1'b0);
    queue_request(1'b0);
    drain();
    reg_write(LettersAddr, '1);
    reg_write(CountAddr, DataW'(2));
    queue_request(1'b1);
    repeat (5) queue_request(1'b0);
    drain();
    reg_write(CountAddr, DataW'(0));
    queue_request(1'b1);
    queue_request(1'b0);
    drain();
    reg_write(LettersAddr, 64'h0123_4567_89AB_CDEF);
    reg_write(CountAddr, DataW'(15));
    queue_request(1'b1);
    queue_request(1'b0);
    queue_request(1'b0);
    queue_request(1'b1);
    drain();
    // Restart at count three; shrinking the count below the current size later ends the run.
    reg_write(CountAddr, DataW'(3));
    queue_request(1'b1);
    repeat (6) queue_request(1'b0);
    drain();
    reg_write(CountAddr, DataW'(1));
    queue_request(1'b0);
    queue_request(1'b0);
    drain();

    while (random_n < RandomItems) begin
      if (random_n + 200 >= RandomItems) calm <= 1'b1;
      case ($urandom_range(0, 3))
        0:       idle_pct = 0;
        1:       idle_pct = 5;
        default: idle_pct = 15;
      endcase
      case ($urandom_range(0, 5))
        0:       lv = '0;
        1:       lv = '1;
        2:       lv = {MaxLetters{8'($urandom)}};
        3:       lv = {(MaxLetters / 2){8'($urandom), 8'($urandom)}};
        default: lv = {$urandom, $urandom};
      endcase
      reg_write(LettersAddr, lv);
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        run_len = $urandom_range(3, 30);
        repeat (run_len) queue_request($urandom_range(0, 29) == 0);
      end else begin
        case ($urandom_range(0, 19))
          0:       cnt = 0;
          1, 2:    cnt = $urandom_range(9, 15);
          3, 4, 5: cnt = $urandom_range(5, 8);
          default: cnt = $urandom_range(1, 4);
        endcase
        pw = {$urandom, $urandom};
        pw[LenW-1:0] = LenW'(cnt);
        reg_write(CountAddr, pw);
        n_eff = (cnt > MaxLetters) ? MaxLetters : cnt;
        total = 0;
        prod = 1;
        for (int k = 1; k <= n_eff; k++) begin
          prod = prod * (n_eff - k + 1);
          total += prod;
        end
        run_len = (total <= 80) ? total + $urandom_range(1, 3) : $urandom_range(20, 150);
        // Mode one keeps the run going against the new count.
        if (mode != 1) queue_request(1'b1);
        repeat (run_len) queue_request($urandom_range(0, 29) == 0);
        run_len += (mode != 1);
      end
      random_n += run_len;
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      fails += pending_words.size();
      $display("%0d expected answers never arrived", pending_words.size());
    end
    $display("Ran %0d requests (%0d restarts) over %0d register writes in %0d cycles.",
             accepted_n, restarts_n, settings_n, cycle_n);
    $display("Checked %0d words and %0d done answers; %0d failures.", words_n, done_n, fails);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
